// ----- rtl/core/i2c_wm_pkg.sv -----
// Package for the write-only I2C master: phase codes, reset constants,
// and the sequencer state and per-tick result structs.
// No dependencies.
`default_nettype none

package i2c_wm_pkg;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_LEAD     = 4'd1;
  localparam logic [3:0] PH_START    = 4'd2;
  localparam logic [3:0] PH_BIT_LO   = 4'd3;
  localparam logic [3:0] PH_BIT_HI   = 4'd4;
  localparam logic [3:0] PH_ACK_LO   = 4'd5;
  localparam logic [3:0] PH_ACK_HI   = 4'd6;
  localparam logic [3:0] PH_WAIT     = 4'd7;
  localparam logic [3:0] PH_STOP_LO  = 4'd8;
  localparam logic [3:0] PH_STOP_SCL = 4'd9;
  localparam logic [3:0] PH_STOP_SDA = 4'd10;

  // tick_count value that marks the address byte on the bus
  localparam logic [1:0] ADDR_MARK = 2'd2;
  localparam logic [7:0] SLAVE_ADDR_RESET = 8'hE0;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] bit_count;
    logic [7:0] shift_byte;
    logic [1:0] tick_count;
    logic       final_flag;
  } seq_state_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic byte_taken;
    logic busy_res;
    logic done_res;
    logic nack;
  } tick_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2c_wm_step.sv -----
// Next-state and per-tick result logic of the I2C write sequencer.
// Purely combinational; uses i2c_wm_pkg.
`default_nettype none

module i2c_wm_step (
  input  i2c_wm_pkg::seq_state_t cur_i,
  input  logic [7:0]             pending_byte_i,
  input  logic [7:0]             slave_address_i,
  input  logic                   req_type_i,
  input  logic [7:0]             byte_in_i,
  input  logic                   byte_last_i,
  input  logic                   sda_in_i,
  output i2c_wm_pkg::seq_state_t nxt_o,
  output logic                   pending_we_o,
  output i2c_wm_pkg::tick_res_t  res_o
);

  logic msb;

  assign msb = cur_i.shift_byte[7];

  always_comb begin
    nxt_o        = cur_i;
    pending_we_o = 1'b0;
    res_o        = '0;
    res_o.scl       = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.sda_drive = 1'b1;
    res_o.busy_res  = 1'b1;

    unique case (cur_i.phase)
      i2c_wm_pkg::PH_LEAD: begin
        if (cur_i.tick_count != 2'd0) begin
          nxt_o.phase      = i2c_wm_pkg::PH_START;
          nxt_o.tick_count = 2'd0;
        end else begin
          nxt_o.tick_count = 2'd1;
        end
      end
      i2c_wm_pkg::PH_START: begin
        res_o.sda_out    = 1'b0;
        nxt_o.shift_byte = slave_address_i;
        nxt_o.bit_count  = 3'd0;
        nxt_o.tick_count = i2c_wm_pkg::ADDR_MARK;
        nxt_o.phase      = i2c_wm_pkg::PH_BIT_LO;
      end
      i2c_wm_pkg::PH_BIT_LO: begin
        res_o.scl     = 1'b0;
        res_o.sda_out = msb;
        nxt_o.phase   = i2c_wm_pkg::PH_BIT_HI;
      end
      i2c_wm_pkg::PH_BIT_HI: begin
        res_o.sda_out    = msb;
        nxt_o.shift_byte = {cur_i.shift_byte[6:0], 1'b0};
        if (cur_i.bit_count == 3'd7) begin
          nxt_o.bit_count = 3'd0;
          nxt_o.phase     = i2c_wm_pkg::PH_ACK_LO;
        end else begin
          nxt_o.bit_count = cur_i.bit_count + 3'd1;
          nxt_o.phase     = i2c_wm_pkg::PH_BIT_LO;
        end
      end
      i2c_wm_pkg::PH_ACK_LO: begin
        res_o.scl       = 1'b0;
        res_o.sda_out   = 1'b0;
        res_o.sda_drive = 1'b0;
        nxt_o.phase     = i2c_wm_pkg::PH_ACK_HI;
      end
      i2c_wm_pkg::PH_ACK_HI: begin
        res_o.sda_out   = 1'b0;
        res_o.sda_drive = 1'b0;
        if (sda_in_i) begin
          res_o.nack       = 1'b1;
          nxt_o.tick_count = 2'd0;
          nxt_o.phase      = i2c_wm_pkg::PH_IDLE;
        end else if (cur_i.tick_count == i2c_wm_pkg::ADDR_MARK) begin
          // address acknowledged: move on to the held first data byte
          nxt_o.tick_count = 2'd0;
          nxt_o.shift_byte = pending_byte_i;
          nxt_o.bit_count  = 3'd0;
          nxt_o.phase      = i2c_wm_pkg::PH_BIT_LO;
        end else if (cur_i.final_flag) begin
          nxt_o.phase = i2c_wm_pkg::PH_STOP_LO;
        end else begin
          nxt_o.phase = i2c_wm_pkg::PH_WAIT;
        end
      end
      i2c_wm_pkg::PH_WAIT: begin
        res_o.scl     = 1'b0;
        res_o.sda_out = 1'b0;
        if (req_type_i) begin
          res_o.byte_taken = 1'b1;
          nxt_o.shift_byte = byte_in_i;
          nxt_o.final_flag = byte_last_i;
          nxt_o.bit_count  = 3'd0;
          nxt_o.phase      = i2c_wm_pkg::PH_BIT_LO;
        end
      end
      i2c_wm_pkg::PH_STOP_LO: begin
        res_o.scl     = 1'b0;
        res_o.sda_out = 1'b0;
        nxt_o.phase   = i2c_wm_pkg::PH_STOP_SCL;
      end
      i2c_wm_pkg::PH_STOP_SCL: begin
        res_o.sda_out = 1'b0;
        nxt_o.phase   = i2c_wm_pkg::PH_STOP_SDA;
      end
      i2c_wm_pkg::PH_STOP_SDA: begin
        res_o.done_res   = 1'b1;
        nxt_o.final_flag = 1'b0;
        nxt_o.phase      = i2c_wm_pkg::PH_IDLE;
      end
      default: begin
        // idle, and any code that means nothing
        res_o.busy_res = 1'b0;
        nxt_o.phase    = i2c_wm_pkg::PH_IDLE;
        if (req_type_i) begin
          res_o.byte_taken = 1'b1;
          res_o.busy_res   = 1'b1;
          pending_we_o     = 1'b1;
          nxt_o.final_flag = byte_last_i;
          nxt_o.tick_count = 2'd0;
          nxt_o.bit_count  = 3'd0;
          nxt_o.phase      = i2c_wm_pkg::PH_LEAD;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_write_master_top.sv -----
// Top level of the write-only I2C master: sequencer registers, output register,
// configuration register and checks. Uses i2c_wm_pkg and i2c_wm_step.
`default_nettype none

// Each accepted input item is one half-bit bus tick and yields exactly one result
// item, in the next cycle, from an output register. The sequencer state updates in
// the same edge that accepts the item, so items are taken every cycle whenever
// the result side takes results every cycle; in_ready_o drops only while a result
// waits unclaimed. A byte offered on an idle tick starts a transaction: two lead-in
// ticks, START, the slave_address byte, then data bytes with an acknowledge phase
// after each; a high SDA at acknowledge aborts with a nack pulse. The user writes
// slave_address (reset 0xE0) via the cfg channel only while no transaction runs; not enforced.

module i2c_write_master_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] byte_in_i,
  input  logic       byte_last_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       sda_drive_o,
  output logic       byte_taken_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       nack_o
);

  i2c_wm_pkg::seq_state_t state_q, state_d;
  i2c_wm_pkg::tick_res_t  res_q, res_d;
  logic [7:0]             pending_byte_q;
  logic [7:0]             slave_address_q;
  logic                   out_valid_q;
  logic                   pending_we;
  logic                   in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  i2c_wm_step u_step (
    .cur_i           (state_q),
    .pending_byte_i  (pending_byte_q),
    .slave_address_i (slave_address_q),
    .req_type_i      (req_type_i),
    .byte_in_i       (byte_in_i),
    .byte_last_i     (byte_last_i),
    .sda_in_i        (sda_in_i),
    .nxt_o           (state_d),
    .pending_we_o    (pending_we),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= '0;
      slave_address_q <= i2c_wm_pkg::SLAVE_ADDR_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        slave_address_q <= cfg_data_i;
      end
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken; pending byte needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
      if (pending_we) begin
        pending_byte_q <= byte_in_i;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_o        = res_q.scl;
  assign sda_out_o    = res_q.sda_out;
  assign sda_drive_o  = res_q.sda_drive;
  assign byte_taken_o = res_q.byte_taken;
  assign busy_res_o   = res_q.busy_res;
  assign done_res_o   = res_q.done_res;
  assign nack_o       = res_q.nack;

`ifndef SYNTHESIS
  a_nack_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_d.nack |=> state_q.phase == i2c_wm_pkg::PH_IDLE)
    else $error("nack did not return the sequencer to idle");

  a_released_sda_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> !sda_out_o && busy_res_o)
    else $error("released SDA shows a level or outside a transaction");

  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q.phase == i2c_wm_pkg::PH_STOP_SDA |=> out_valid_o && done_res_o)
    else $error("STOP completion did not report done");

  a_taken_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_taken_o |-> busy_res_o && !nack_o && !done_res_o)
    else $error("byte taken outside a running transaction");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the write-only I2C master (i2c_write_master_top).
// Predicts every bus tick from its own sequencer model and checks each result item.
// Depends on i2c_wm_pkg for the phase codes, reset constants and the result struct.
`timescale 1ns / 1ps

module tb_top;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       req_type_i;
  logic [7:0] byte_in_i;
  logic       byte_last_i;
  logic       sda_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       scl_o;
  logic       sda_out_o;
  logic       sda_drive_o;
  logic       byte_taken_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       nack_o;

  i2c_write_master_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .byte_in_i    (byte_in_i),
    .byte_last_i  (byte_last_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_o        (scl_o),
    .sda_out_o    (sda_out_o),
    .sda_drive_o  (sda_drive_o),
    .byte_taken_o (byte_taken_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .nack_o       (nack_o)
  );

  // sequencer model state
  logic [3:0] seq_phase   = i2c_wm_pkg::PH_IDLE;
  logic [2:0] seq_bits    = '0;
  logic [7:0] seq_shift   = '0;
  logic [7:0] seq_pending = '0;
  logic [1:0] seq_lead    = '0;
  logic       seq_final   = 1'b0;
  logic [7:0] cfg_addr    = i2c_wm_pkg::SLAVE_ADDR_RESET;

  i2c_wm_pkg::tick_res_t expected_ticks[$];
  logic [7:0] frame_bytes[$];
  int         mismatches  = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         holdoff_len = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // one bus tick of the sequencer: advance the model, return the expected levels
  function automatic i2c_wm_pkg::tick_res_t step_bus(input logic req,
                                                     input logic [7:0] data,
                                                     input logic last, input logic sda);
    i2c_wm_pkg::tick_res_t r;
    logic                  msb;
    logic [3:0]            ph;
    msb = seq_shift[7];
    ph  = (seq_phase > i2c_wm_pkg::PH_STOP_SDA) ? i2c_wm_pkg::PH_IDLE : seq_phase;
    r = '0;
    r.scl       = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b1;
    r.busy_res  = (ph != i2c_wm_pkg::PH_IDLE);
    case (ph)
      i2c_wm_pkg::PH_LEAD: begin
        if (seq_lead >= 2'd1) begin
          seq_phase = i2c_wm_pkg::PH_START;
          seq_lead  = 2'd0;
        end else begin
          seq_lead = 2'd1;
        end
      end
      i2c_wm_pkg::PH_START: begin
        r.sda_out = 1'b0;
        seq_shift = cfg_addr;
        seq_bits  = 3'd0;
        seq_lead  = i2c_wm_pkg::ADDR_MARK;
        seq_phase = i2c_wm_pkg::PH_BIT_LO;
      end
      i2c_wm_pkg::PH_BIT_LO: begin
        r.scl     = 1'b0;
        r.sda_out = msb;
        seq_phase = i2c_wm_pkg::PH_BIT_HI;
      end
      i2c_wm_pkg::PH_BIT_HI: begin
        r.sda_out = msb;
        seq_shift = {seq_shift[6:0], 1'b0};
        if (seq_bits == 3'd7) begin
          seq_bits  = 3'd0;
          seq_phase = i2c_wm_pkg::PH_ACK_LO;
        end else begin
          seq_bits  = seq_bits + 3'd1;
          seq_phase = i2c_wm_pkg::PH_BIT_LO;
        end
      end
      i2c_wm_pkg::PH_ACK_LO: begin
        r.scl       = 1'b0;
        r.sda_out   = 1'b0;
        r.sda_drive = 1'b0;
        seq_phase   = i2c_wm_pkg::PH_ACK_HI;
      end
      i2c_wm_pkg::PH_ACK_HI: begin
        r.sda_out   = 1'b0;
        r.sda_drive = 1'b0;
        if (sda) begin
          r.nack    = 1'b1;
          seq_lead  = 2'd0;
          seq_phase = i2c_wm_pkg::PH_IDLE;
        end else if (seq_lead == i2c_wm_pkg::ADDR_MARK) begin
          // address acknowledged: move on to the byte held since the start
          seq_lead  = 2'd0;
          seq_shift = seq_pending;
          seq_bits  = 3'd0;
          seq_phase = i2c_wm_pkg::PH_BIT_LO;
        end else if (seq_final) begin
          seq_phase = i2c_wm_pkg::PH_STOP_LO;
        end else begin
          seq_phase = i2c_wm_pkg::PH_WAIT;
        end
      end
      i2c_wm_pkg::PH_WAIT: begin
        r.scl     = 1'b0;
        r.sda_out = 1'b0;
        if (req) begin
          r.byte_taken = 1'b1;
          seq_shift    = data;
          seq_final    = last;
          seq_bits     = 3'd0;
          seq_phase    = i2c_wm_pkg::PH_BIT_LO;
        end
      end
      i2c_wm_pkg::PH_STOP_LO: begin
        r.scl     = 1'b0;
        r.sda_out = 1'b0;
        seq_phase = i2c_wm_pkg::PH_STOP_SCL;
      end
      i2c_wm_pkg::PH_STOP_SCL: begin
        r.sda_out = 1'b0;
        seq_phase = i2c_wm_pkg::PH_STOP_SDA;
      end
      i2c_wm_pkg::PH_STOP_SDA: begin
        r.done_res = 1'b1;
        seq_final  = 1'b0;
        seq_phase  = i2c_wm_pkg::PH_IDLE;
      end
      default: begin
        seq_phase = i2c_wm_pkg::PH_IDLE;
        if (req) begin
          r.byte_taken = 1'b1;
          r.busy_res   = 1'b1;
          seq_pending  = data;
          seq_final    = last;
          seq_lead     = 2'd0;
          seq_bits     = 3'd0;
          seq_phase    = i2c_wm_pkg::PH_LEAD;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0b got %0b", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // predict on each accepted item, check each accepted result item
  always @(posedge clk_i) begin
    i2c_wm_pkg::tick_res_t exp_r;
    if (cfg_valid_i && cfg_ready_o) cfg_addr = cfg_data_i;
    if (in_valid_i && in_ready_o)
      expected_ticks.push_back(step_bus(req_type_i, byte_in_i, byte_last_i, sda_in_i));
    if (out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: result item with no tick pending", $time);
        mismatches++;
      end else begin
        exp_r = expected_ticks.pop_front();
        check_field("scl", exp_r.scl, scl_o);
        check_field("sda_out", exp_r.sda_out, sda_out_o);
        check_field("sda_drive", exp_r.sda_drive, sda_drive_o);
        check_field("byte_taken", exp_r.byte_taken, byte_taken_o);
        check_field("busy", exp_r.busy_res, busy_res_o);
        check_field("done", exp_r.done_res, done_res_o);
        check_field("nack", exp_r.nack, nack_o);
      end
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (holdoff_len) @(negedge clk_i);
        holdoff_len = 0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_tick(input logic req, input logic [7:0] data, input logic last,
                           input logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    byte_in_i   <= data;
    byte_last_i <= last;
    sda_in_i    <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every pending tick has come back
  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (expected_ticks.size() == 0);
    @(negedge clk_i);
  endtask

  // mostly well-formed traffic chosen from the current bus phase; noisy = all random
  task automatic send_shaped(input bit noisy, input bit closing);
    logic       r, l, s;
    logic [7:0] b;
    b = 8'($urandom_range(255));
    r = 1'($urandom_range(1));
    l = 1'($urandom_range(1));
    s = 1'($urandom_range(1));
    if (!noisy) begin
      case (seq_phase)
        i2c_wm_pkg::PH_IDLE: begin
          r = !closing && ($urandom_range(9) < 7);
          l = ($urandom_range(2) == 0);
        end
        i2c_wm_pkg::PH_ACK_HI: begin
          s = !closing && ($urandom_range(15) == 0);
          r = ($urandom_range(7) == 0);
        end
        i2c_wm_pkg::PH_WAIT: begin
          r = closing || ($urandom_range(3) != 0);
          l = closing || ($urandom_range(2) == 0);
        end
        default: r = ($urandom_range(7) == 0);
      endcase
    end
    send_tick(r, b, l, s);
  endtask

  task automatic finish_frame;
    while (seq_phase != i2c_wm_pkg::PH_IDLE) send_shaped(1'b0, 1'b1);
    drain();
  endtask

  task automatic write_addr(input logic [7:0] addr);
    finish_frame();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one transaction carrying frame_bytes; nack on acknowledge number nack_at
  // (0 = address), poke offers stray bytes while the bus is busy
  task automatic send_frame(input int nack_at, input bit poke);
    int         acks;
    int         idx;
    int         waits;
    logic [7:0] b;
    acks  = 0;
    idx   = 1;
    waits = 0;
    send_tick(1'b1, frame_bytes[0], frame_bytes.size() == 1, 1'b0);
    while (seq_phase != i2c_wm_pkg::PH_IDLE) begin
      b = 8'($urandom_range(255));
      case (seq_phase)
        i2c_wm_pkg::PH_ACK_HI: begin
          send_tick(1'b0, b, 1'b0, acks == nack_at);
          acks++;
        end
        i2c_wm_pkg::PH_WAIT: begin
          if (waits < 2) begin
            send_tick(1'b0, b, 1'b1, 1'b0);
            waits++;
          end else begin
            send_tick(1'b1, frame_bytes[idx], idx == frame_bytes.size() - 1, 1'b0);
            idx++;
            waits = 0;
          end
        end
        // SDA input is ignored outside acknowledge, so hold it high here
        default: send_tick(poke, b, 1'b1, 1'b1);
      endcase
    end
  endtask

  task automatic test_reset_address;
    send_tick(1'b0, 8'h00, 1'b0, 1'b0);
    send_tick(1'b0, 8'hFF, 1'b1, 1'b1);
    frame_bytes = '{8'hFF};
    send_frame(-1, 1'b0);
  endtask

  task automatic test_address_extremes;
    write_addr(8'h00);
    frame_bytes = '{8'h00, 8'hFF};
    send_frame(-1, 1'b1);
    write_addr(8'hFF);
    frame_bytes = '{8'h3C};
    send_frame(0, 1'b0);
  endtask

  task automatic test_data_nack;
    frame_bytes = '{8'hC3, 8'h7E};
    send_frame(1, 1'b1);
    frame_bytes = '{8'h81, 8'h18, 8'h42};
    send_frame(3, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_items; i++) send_shaped($urandom_range(9) == 0, 1'b0);
    write_addr(8'($urandom_range(255)));
  endtask

  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holdoff_len = 60;
    while (holdoff_len != 0) send_shaped(1'b0, 1'b0);
    drain();
    for (int i = 0; i < 40; i++) send_shaped(1'b0, 1'b0);
    finish_frame();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = 1'b0;
    byte_in_i   = '0;
    byte_last_i = 1'b0;
    sda_in_i    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_address();
    test_address_extremes();
    test_data_nack();
    test_random_traffic(200, 18, 79);
    test_random_traffic(200, 79, 18);
    test_random_traffic(200, 0, 0);
    test_backpressure();

    rx_idle_pct = 0;
    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/i2c_wm_pkg.sv
rtl/core/i2c_wm_step.sv
rtl/core/i2c_write_master_top.sv
tb/tb_top.sv
